// File: sv/wpd_pkg.sv
// Shared types, constants and the arctangent table for the waypoint heading and distance unit.
package wpd_pkg;

    // Item opcodes on the input channel.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_POLL    = 2'd2
    } opcode_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SOLVE,
        ST_ISSUE
    } top_state_t;

    // States of the iterative vectoring unit.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_SCALE,
        CS_ROUND
    } cordic_state_t;

    // Field widths fixed by the interface.
    localparam int COORD_W   = 16;
    localparam int DELTA_W   = 17;
    localparam int HEADING_W = 16;
    localparam int DIST_W    = 17;
    localparam int SLOT_W    = 4;
    localparam int LENGTH_W  = 5;

    // Datapath widths of the vectoring unit.
    localparam int GUARD_BITS = 12;
    localparam int XY_W       = 32;
    localparam int Z_W        = 27;
    localparam int STEP_W     = 5;
    localparam int ATAN_W     = 22;
    localparam int ATAN_ENTRIES = 24;
    localparam int PROD_W     = 63;

    // Angle constants in 1/65536 degree and the output heading scale.
    localparam logic signed [Z_W-1:0] HALF_TURN_Z = 27'sd11796480;
    localparam logic signed [Z_W:0]   ROUND_Z     = 28'sd256;
    localparam int                    Z_SHIFT     = 9;
    localparam int                    HW_W        = Z_W + 1 - Z_SHIFT;
    localparam logic signed [HW_W-1:0] FULL_TURN  = 19'sd46080;

    // Inverse CORDIC gain in Q0.32 and the rounding bias for the Q44 product.
    localparam logic [31:0] INV_GAIN   = 32'd2608131496;
    localparam logic [63:0] ROUND_BIAS = 64'h0000_0800_0000_0000;

    // One stored waypoint.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // Result of one vectoring run.
    typedef struct packed {
        logic [HEADING_W-1:0] heading;
        logic [DIST_W-1:0]    distance;
    } solve_res_t;

    // atan(2^-i) in 1/65536 degree, rounded to the nearest unit.
    function automatic logic [ATAN_W-1:0] atan_z(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/waypoint_heading_distance.sv
// A poll that issues a waypoint reads the table, runs the CORDIC loop one step per cycle, then
// scales and rounds the result and hands it to the output register, waiting while that is full.
// Input is not ready from an issuing poll until its result enters the output register; load,
// restart and other polls keep it ready. A finished result waits there while a new beat is taken.
// Reset (synchronous, active low) clears the path length, the path index and the output valid;
// the waypoint table is not cleared and holds nothing meaningful until loaded.
module waypoint_heading_distance import wpd_pkg::*; #(
    parameter int PATH_DEPTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [SLOT_W-1:0]     s_point_index,
    input  logic signed [15:0]    s_point_x,
    input  logic signed [15:0]    s_point_y,
    input  logic [LENGTH_W-1:0]   s_path_length,
    input  logic signed [15:0]    s_pose_x,
    input  logic signed [15:0]    s_pose_y,
    input  logic                  s_motion_idle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [HEADING_W-1:0]  m_target_heading,
    output logic [DIST_W-1:0]     m_target_distance,
    output logic [SLOT_W-1:0]     m_issued_index,
    output logic                  m_final_point
);

    localparam int IDX_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int LEN_W = $clog2(PATH_DEPTH + 1);

    top_state_t                 state_reg, state_next;
    logic [LEN_W-1:0]           next_index_reg;
    logic [LEN_W-1:0]           active_length_reg;
    logic signed [COORD_W-1:0]  pose_x_reg, pose_y_reg;
    logic                       m_valid_reg;
    logic [HEADING_W-1:0]       heading_reg;
    logic [DIST_W-1:0]          distance_reg;
    logic [SLOT_W-1:0]          issued_index_reg;
    logic                       final_point_reg;

    logic                       accept;
    logic                       issue_go;
    logic                       out_load;
    logic                       load_en;
    point_t                     load_point;
    point_t                     rd_point;
    logic signed [DELTA_W-1:0]  delta_x, delta_y;
    logic                       solve_start;
    logic                       solve_done;
    solve_res_t                 solve_res;
    logic [LEN_W:0]             index_plus;

    assign accept   = s_valid && s_ready;
    assign issue_go = accept && (s_opcode == OP_POLL) && s_motion_idle
                      && (next_index_reg < active_length_reg);
    assign out_load = (state_reg == ST_ISSUE) && (!m_valid_reg || m_ready);
    assign load_en  = accept && (s_opcode == OP_LOAD) && (32'(s_point_index) < PATH_DEPTH);
    assign load_point.x = s_point_x;
    assign load_point.y = s_point_y;
    assign solve_start  = (state_reg == ST_READ);
    assign index_plus   = {1'b0, next_index_reg} + 1'b1;

    // Offset from the car to the waypoint, 17-bit signed.
    assign delta_x = {rd_point.x[COORD_W-1], rd_point.x} - {pose_x_reg[COORD_W-1], pose_x_reg};
    assign delta_y = {rd_point.y[COORD_W-1], rd_point.y} - {pose_y_reg[COORD_W-1], pose_y_reg};

    // Waypoint table, read at the current path index.
    wpd_store #(
        .DEPTH (PATH_DEPTH),
        .AW    (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (IDX_W'(s_point_index)),
        .wr_data (load_point),
        .rd_addr (next_index_reg[IDX_W-1:0]),
        .rd_data (rd_point)
    );

    // Vectoring unit that solves each issuing poll.
    wpd_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (solve_start),
        .dx      (delta_x),
        .dy      (delta_y),
        .done    (solve_done),
        .result  (solve_res)
    );

    // Sequencer: read the table, run the CORDIC, then hand over to the output register.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (issue_go) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_SOLVE;
            ST_SOLVE: begin
                if (solve_done) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Path control: restart sets the length and rewinds, an issue advances the index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_index_reg    <= '0;
            active_length_reg <= '0;
        end else if (accept && (s_opcode == OP_RESTART)) begin
            next_index_reg <= '0;
            if (32'(s_path_length) > PATH_DEPTH) begin
                active_length_reg <= LEN_W'(PATH_DEPTH);
            end else begin
                active_length_reg <= LEN_W'(s_path_length);
            end
        end else if (out_load) begin
            next_index_reg <= index_plus[LEN_W-1:0];
        end
    end

    // Pose captured from the poll beat that starts a solve.
    always_ff @(posedge aclk) begin
        if (issue_go) begin
            pose_x_reg <= s_pose_x;
            pose_y_reg <= s_pose_y;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            heading_reg      <= solve_res.heading;
            distance_reg     <= solve_res.distance;
            issued_index_reg <= SLOT_W'(next_index_reg);
            final_point_reg  <= (index_plus == {1'b0, active_length_reg});
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_target_heading  = heading_reg;
    assign m_target_distance = distance_reg;
    assign m_issued_index    = issued_index_reg;
    assign m_final_point     = final_point_reg;

endmodule

// File: sv/wpd_store.sv
// Waypoint table: single-port-write memory with a registered read port.
module wpd_store import wpd_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  point_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output point_t        rd_data
);

    point_t mem [DEPTH];
    point_t rd_data_reg;

    // Write port: one waypoint per load beat.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: data appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/wpd_cordic.sv
// Iterative CORDIC in vectoring mode giving heading and scaled magnitude of an offset.
module wpd_cordic import wpd_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [DELTA_W-1:0] dx,
    input  logic signed [DELTA_W-1:0] dy,
    output logic                      done,
    output solve_res_t                result
);

    // The table holds ATAN_ENTRIES angles, so no more steps than that are run.
    localparam int N_ITER = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_ITER - 1);

    cordic_state_t           state_reg, state_next;
    logic signed [XY_W-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    zero_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [HEADING_W-1:0]    heading_reg;
    logic                    done_reg;
    solve_res_t              result_reg;

    logic signed [XY_W-1:0]  x_init, y_init, x_shift, y_shift;
    logic signed [Z_W-1:0]   atan_step;
    logic [XY_W-2:0]         x_clamp;
    logic signed [Z_W:0]     z_round;
    logic signed [HW_W-1:0]  z_whole, z_wrap;
    logic [63:0]             dist_sum;
    logic [63-44:0]          dist_raw;
    logic [DIST_W-1:0]       dist_sat;

    // Next-state logic of the iteration sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    state_next = CS_ITER;
                end
            end
            CS_ITER: begin
                if (step_reg == LAST_STEP) begin
                    state_next = CS_SCALE;
                end
            end
            CS_SCALE: state_next = CS_ROUND;
            CS_ROUND: state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == CS_ROUND);
        end
    end

    // Scale the offset by the guard bits; the left half-plane is folded over when a run starts.
    always_comb begin
        x_init = {{(XY_W - DELTA_W - GUARD_BITS){dx[DELTA_W-1]}}, dx, {GUARD_BITS{1'b0}}};
        y_init = {{(XY_W - DELTA_W - GUARD_BITS){dy[DELTA_W-1]}}, dy, {GUARD_BITS{1'b0}}};
    end

    // One micro-rotation per cycle; arithmetic shifts floor as required.
    always_comb begin
        x_shift   = x_reg >>> step_reg;
        y_shift   = y_reg >>> step_reg;
        atan_step = Z_W'(signed'({1'b0, atan_z(step_reg)}));
    end

    // Heading: round to 1/128 degree and wrap into one turn; also clamp a negative x to zero.
    always_comb begin
        z_round = (Z_W + 1)'(z_reg) + ROUND_Z;
        z_whole = HW_W'(z_round >>> Z_SHIFT);
        if (z_whole < 0) begin
            z_wrap = z_whole + FULL_TURN;
        end else if (z_whole >= FULL_TURN) begin
            z_wrap = z_whole - FULL_TURN;
        end else begin
            z_wrap = z_whole;
        end
        x_clamp = x_reg[XY_W-1] ? '0 : x_reg[XY_W-2:0];
    end

    // Distance: drop the CORDIC gain, round and saturate.
    always_comb begin
        dist_sum = {1'b0, prod_reg} + ROUND_BIAS;
        dist_raw = dist_sum[63:44];
        dist_sat = (|dist_raw[19:DIST_W]) ? {DIST_W{1'b1}} : dist_raw[DIST_W-1:0];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    zero_reg <= (dx == '0) && (dy == '0);
                    step_reg <= '0;
                    if (dx[DELTA_W-1]) begin
                        x_reg <= -x_init;
                        y_reg <= -y_init;
                        z_reg <= HALF_TURN_Z;
                    end else begin
                        x_reg <= x_init;
                        y_reg <= y_init;
                        z_reg <= '0;
                    end
                end
            end
            CS_ITER: begin
                step_reg <= step_reg + 1'b1;
                if (!y_reg[XY_W-1]) begin
                    x_reg <= x_reg + y_shift;
                    y_reg <= y_reg - x_shift;
                    z_reg <= z_reg + atan_step;
                end else begin
                    x_reg <= x_reg - y_shift;
                    y_reg <= y_reg + x_shift;
                    z_reg <= z_reg - atan_step;
                end
            end
            CS_SCALE: begin
                prod_reg    <= x_clamp * INV_GAIN;
                heading_reg <= HEADING_W'(z_wrap);
            end
            CS_ROUND: begin
                result_reg.heading  <= zero_reg ? '0 : heading_reg;
                result_reg.distance <= zero_reg ? '0 : dist_sat;
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/wpd_checker.sv
// Port-level checks for the waypoint heading and distance unit, bound to the top level.
module wpd_checker import wpd_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [1:0]            s_opcode,
    input logic [SLOT_W-1:0]     s_point_index,
    input logic signed [15:0]    s_point_x,
    input logic signed [15:0]    s_point_y,
    input logic [LENGTH_W-1:0]   s_path_length,
    input logic signed [15:0]    s_pose_x,
    input logic signed [15:0]    s_pose_y,
    input logic                  s_motion_idle,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [HEADING_W-1:0]  m_target_heading,
    input logic [DIST_W-1:0]     m_target_distance,
    input logic [SLOT_W-1:0]     m_issued_index,
    input logic                  m_final_point
);

    // A result beat that is not taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_target_heading)
            && $stable(m_target_distance) && $stable(m_issued_index)
            && $stable(m_final_point))
    else $error("result beat changed while stalled");

    // The heading always lies within one turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_target_heading) < 46080))
    else $error("heading outside one turn");

    // Load and restart beats never block the input channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == OP_LOAD || s_opcode == OP_RESTART) |=> s_ready)
    else $error("input channel blocked after a table beat");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result valid after reset");

endmodule

bind waypoint_heading_distance wpd_checker u_wpd_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the waypoint heading and distance unit.
`timescale 1ns / 100ps

module tb;
    import wpd_pkg::*;

    localparam int PATH_SLOTS   = 16;
    localparam int CORDIC_ITERS = 16;
    localparam int DRAIN_CYCLES = 4 * (CORDIC_ITERS + 5);
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One input beat, every field carried whatever the opcode.
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         index;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [4:0]         len;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic               idle;
    } beat_t;

    // One issued waypoint as the block should report it.
    typedef struct packed {
        logic [15:0] heading;
        logic [16:0] distance;
        logic [3:0]  slot;
        logic        last;
    } issue_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_opcode = '0;
    logic [3:0]           s_point_index = '0;
    logic signed [15:0]   s_point_x = '0;
    logic signed [15:0]   s_point_y = '0;
    logic [4:0]           s_path_length = '0;
    logic signed [15:0]   s_pose_x = '0;
    logic signed [15:0]   s_pose_y = '0;
    logic                 s_motion_idle = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [15:0]          m_target_heading;
    logic [16:0]          m_target_distance;
    logic [3:0]           m_issued_index;
    logic                 m_final_point;

    // Predictor state: the waypoint table, the path length and the path index.
    logic signed [15:0] way_x [PATH_SLOTS];
    logic signed [15:0] way_y [PATH_SLOTS];
    bit                 slot_loaded [PATH_SLOTS];
    int                 path_len = 0;
    int                 path_next = 0;

    issue_t issues_due [$];
    int     error_count = 0;
    int     beats_sent = 0;
    int     send_idle_pct = 37;
    int     recv_stall_pct = 79;

    // atan(2^-i) in 1/65536 degree.
    longint atan_step_z [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};

    waypoint_heading_distance #(
        .PATH_DEPTH   (PATH_SLOTS),
        .CORDIC_STEPS (CORDIC_ITERS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_point_index     (s_point_index),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_path_length     (s_path_length),
        .s_pose_x          (s_pose_x),
        .s_pose_y          (s_pose_y),
        .s_motion_idle     (s_motion_idle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_target_heading  (m_target_heading),
        .m_target_distance (m_target_distance),
        .m_issued_index    (m_issued_index),
        .m_final_point     (m_final_point)
    );

    always #1 aclk = ~aclk;

    // Vectoring CORDIC: heading in 1/128 degree and distance in Q17.0 metres.
    function automatic void solve_heading_distance(input int dx, input int dy,
                                                   output logic [15:0] heading,
                                                   output logic [16:0] distance);
        longint          x, y, z, nx, ny, t;
        longint unsigned d;
        int              i;
        if (dx == 0 && dy == 0) begin
            heading  = '0;
            distance = '0;
            return;
        end
        x = longint'(dx) * 4096;
        y = longint'(dy) * 4096;
        z = 0;
        // The left half-plane is folded over, starting the angle at 180 degrees.
        if (dx < 0) begin
            x = -x;
            y = -y;
            z = 11796480;
        end
        for (i = 0; i < CORDIC_ITERS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_step_z[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_step_z[i];
            end
            x = nx;
            y = ny;
        end
        t = z + 2 * 46080 * 512 + 256;
        heading = 16'((t / 512) % 46080);
        if (x < 0) x = 0;
        // Remove the CORDIC gain with a rounded Q0.32 multiply, then saturate.
        d = ($unsigned(x) * 64'd2608131496 + (64'd1 << 43)) >> 44;
        if (d > 64'd131071) d = 64'd131071;
        distance = d[16:0];
    endfunction

    // Update the predicted state for an accepted beat and queue any issue it causes.
    function automatic void forecast_beat(input beat_t b);
        issue_t exp;
        int     dx, dy;
        case (b.op)
            OP_LOAD: begin
                way_x[b.index]       = b.px;
                way_y[b.index]       = b.py;
                slot_loaded[b.index] = 1'b1;
            end
            OP_RESTART: begin
                path_len  = (b.len > PATH_SLOTS) ? PATH_SLOTS : int'(b.len);
                path_next = 0;
            end
            OP_POLL: begin
                if (b.idle && path_next < path_len) begin
                    dx = int'(way_x[path_next]) - int'(b.qx);
                    dy = int'(way_y[path_next]) - int'(b.qy);
                    solve_heading_distance(dx, dy, exp.heading, exp.distance);
                    exp.slot = 4'(path_next);
                    exp.last = (path_next + 1 == path_len);
                    issues_due.push_back(exp);
                    path_next++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return 16'(int'($urandom_range(511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Fully random beat; builders below override the fields their opcode uses.
    function automatic beat_t random_beat();
        beat_t b;
        b.op    = 2'($urandom_range(3));
        b.index = 4'($urandom);
        b.px    = rand_coord();
        b.py    = rand_coord();
        b.len   = 5'($urandom);
        b.qx    = rand_coord();
        b.qy    = rand_coord();
        b.idle  = 1'($urandom);
        return b;
    endfunction

    function automatic beat_t load_beat(input logic [3:0] slot,
                                        input logic signed [15:0] x,
                                        input logic signed [15:0] y);
        beat_t b;
        b       = random_beat();
        b.op    = OP_LOAD;
        b.index = slot;
        b.px    = x;
        b.py    = y;
        return b;
    endfunction

    function automatic beat_t restart_beat(input logic [4:0] len);
        beat_t b;
        b     = random_beat();
        b.op  = OP_RESTART;
        b.len = len;
        return b;
    endfunction

    function automatic beat_t poll_beat(input logic signed [15:0] x,
                                        input logic signed [15:0] y, input logic idle);
        beat_t b;
        b      = random_beat();
        b.op   = OP_POLL;
        b.qx   = x;
        b.qy   = y;
        b.idle = idle;
        return b;
    endfunction

    // Poll with a pose that is often on or close to the next waypoint.
    function automatic beat_t aimed_poll();
        logic [3:0] slot;
        logic       idle;
        slot = 4'(path_next);
        idle = ($urandom_range(4) != 0);
        // A slot not yet loaded has no position to aim at.
        if (!slot_loaded[slot]) begin
            return poll_beat(rand_coord(), rand_coord(), idle);
        end
        case ($urandom_range(7))
            0: return poll_beat(way_x[slot], way_y[slot], idle);
            1, 2, 3: return poll_beat(way_x[slot] - 16'(int'($urandom_range(511)) - 256),
                                      way_y[slot] - 16'(int'($urandom_range(511)) - 256),
                                      idle);
            default: return poll_beat(rand_coord(), rand_coord(), idle);
        endcase
    endfunction

    // Offer one beat and wait for it to be taken. A poll that would read a slot
    // never loaded is preceded by a load of that slot.
    task automatic send_beat(input beat_t b);
        beat_t cur;
        bit    done;
        done = 1'b0;
        while (!done) begin
            cur = b;
            if (b.op == OP_POLL && b.idle && path_next < path_len && !slot_loaded[path_next])
            begin
                cur = load_beat(4'(path_next), rand_coord(), rand_coord());
            end else begin
                done = 1'b1;
            end
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid       <= 1'b1;
            s_opcode      <= cur.op;
            s_point_index <= cur.index;
            s_point_x     <= cur.px;
            s_point_y     <= cur.py;
            s_path_length <= cur.len;
            s_pose_x      <= cur.qx;
            s_pose_y      <= cur.qy;
            s_motion_idle <= cur.idle;
            do @(posedge aclk); while (!s_ready);
            forecast_beat(cur);
            if (cur.op != OP_UNUSED) beats_sent++;
        end
    endtask

    // Result side: random back-pressure and a field-by-field check of each beat.
    always @(posedge aclk) begin
        issue_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (issues_due.size() == 0) begin
                $error("unexpected result: heading %0d distance %0d index %0d",
                       m_target_heading, m_target_distance, m_issued_index);
                error_count++;
            end else begin
                exp = issues_due.pop_front();
                if (m_target_heading !== exp.heading) begin
                    $error("target_heading: expected %0d, got %0d",
                           exp.heading, m_target_heading);
                    error_count++;
                end
                if (m_target_distance !== exp.distance) begin
                    $error("target_distance: expected %0d, got %0d",
                           exp.distance, m_target_distance);
                    error_count++;
                end
                if (m_issued_index !== exp.slot) begin
                    $error("issued_index: expected %0d, got %0d", exp.slot, m_issued_index);
                    error_count++;
                end
                if (m_final_point !== exp.last) begin
                    $error("final_point: expected %0d, got %0d", exp.last, m_final_point);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Extreme coordinates, every opcode and the corner cases of the path logic.
    task automatic test_directed_cases();
        send_beat(load_beat(4'd0, 16'sh7FFF, 16'sh7FFF));
        send_beat(load_beat(4'd1, 16'sh8000, 16'sh8000));
        send_beat(load_beat(4'd2, 16'sh0000, 16'sh0000));
        send_beat(load_beat(4'd3, 16'sd100, -16'sd4000));
        send_beat(restart_beat(5'd4));
        // Largest positive offset on both axes.
        send_beat(poll_beat(16'sh8000, 16'sh8000, 1'b1));
        // Executor busy: nothing is issued and the index holds.
        send_beat(poll_beat(16'sh0000, 16'sh0000, 1'b0));
        // Largest negative offset on both axes.
        send_beat(poll_beat(16'sh7FFF, 16'sh7FFF, 1'b1));
        // Zero offset.
        send_beat(poll_beat(16'sh0000, 16'sh0000, 1'b1));
        // Straight down, last point of the path.
        send_beat(poll_beat(16'sd100, 16'sd5000, 1'b1));
        // Path exhausted.
        send_beat(poll_beat(16'sh0000, 16'sh0000, 1'b1));
        send_beat(poll_beat(16'sh0000, 16'sh0000, 1'b1));
        // Unused opcode is ignored.
        begin
            beat_t junk;
            junk    = random_beat();
            junk.op = OP_UNUSED;
            send_beat(junk);
        end
        // Overlong restart saturates to the table depth.
        send_beat(restart_beat(5'd31));
        send_beat(poll_beat(16'sh7FFF, 16'sh8000, 1'b1));
        // Straight left, exactly 180 degrees.
        send_beat(poll_beat(16'sh0000, 16'sh8000, 1'b1));
        send_beat(poll_beat(-16'sd1, 16'sh0000, 1'b1));
        send_beat(poll_beat(16'sd101, -16'sd4001, 1'b1));
        // Empty path issues nothing.
        send_beat(restart_beat(5'd0));
        send_beat(poll_beat(16'sh0000, 16'sh0000, 1'b1));
        // A one-point path is final at once.
        send_beat(restart_beat(5'd1));
        send_beat(poll_beat(rand_coord(), rand_coord(), 1'b1));
    endtask

    // Mostly whole paths with random content, mixed with stray beats and restarts.
    task automatic test_path_sequences(input int quota);
        int stop_at, len, polls, s;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at) begin
            case ($urandom_range(9))
                0: send_beat(random_beat());
                1: send_beat(restart_beat(5'($urandom_range(31))));
                default: begin
                    len = $urandom_range(1, PATH_SLOTS);
                    for (s = 0; s < len; s++) begin
                        if (!slot_loaded[s] || $urandom_range(3) != 0)
                            send_beat(load_beat(4'(s), rand_coord(), rand_coord()));
                    end
                    send_beat(restart_beat(5'(len)));
                    polls = 0;
                    while (path_next < path_len && polls < 4 * len) begin
                        if ($urandom_range(19) == 0) send_beat(random_beat());
                        else send_beat(aimed_poll());
                        polls++;
                    end
                    if ($urandom_range(1) == 0) send_beat(aimed_poll());
                end
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_path_sequences(580);

        send_idle_pct  = 79;
        recv_stall_pct = 37;
        test_path_sequences(580);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_path_sequences(590);

        // Let every outstanding result drain before the verdict.
        s_valid <= 1'b0;
        while (issues_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
